// ===== hw/rtl/pps_pkg.sv =====
`timescale 1ns / 1ps
package pps_pkg;

  localparam int unsigned PidW = 6;

  typedef enum logic [3:0] {
    FN_ADD     = 4'd0,
    FN_EXIT    = 4'd1,
    FN_WAIT    = 4'd2,
    FN_BLOCK   = 4'd3,
    FN_UNBLOCK = 4'd4,
    FN_TERM    = 4'd5,
    FN_LINK    = 4'd6,
    FN_ALLOC   = 4'd7,
    FN_READ    = 4'd8
  } func_e;

  typedef enum logic [2:0] {
    ST_NEW        = 3'd0,
    ST_READY      = 3'd1,
    ST_RUNNING    = 3'd2,
    ST_WAITING    = 3'd3,
    ST_TERMINATED = 3'd4
  } pstate_e;

  localparam logic [PidW-1:0] PidMax = 6'd63;

endpackage

// ===== hw/rtl/priority_process_scheduler_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Signals
// command   in         start_i, busy_o, func_i, pid_i, priority_req_i, parent_pid_i
// result    out        done_o, current_pid_o, current_valid_o, ok_o, pid_state_o,
//                      pid_parent_o, allocated_pid_o
// config    in         cfg_we_i, cfg_wdata_i
//
// An item holds the block from the edge that accepts it to the edge that takes its result;
// no new command is taken meanwhile. The entry memory has one read and one write port:
// the best-entry search and the refresh each sweep all entries, one read per cycle, and
// the refresh writes each ready entry. With nothing ready after the command the refresh
// sweep is skipped. A read, an allocate or an ignored command skips the action state.
// Exit with a waiting parent and link child add a parent read and a parent write. Wait
// for child adds a reap search over up to all entries, then rereads and rewrites the
// current entry through the link states.
// Reset clears control state and the ready and waiting bitmaps at once. The entry memory
// has no reset: a clearing sweep over all entries runs after reset, with busy_o high.
// The receiver cannot stall: done_o marks each result for exactly one cycle.
module priority_process_scheduler_core #(
  parameter int unsigned MAX_PROCS     = 64,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [3:0]            func_i,
  input  logic [pps_pkg::PidW-1:0] pid_i,
  input  logic [7:0]            priority_req_i,
  input  logic [pps_pkg::PidW-1:0] parent_pid_i,
  input  logic                  cfg_we_i,
  input  logic [5:0]            cfg_wdata_i,
  output logic                  done_o,
  output logic [5:0]            current_pid_o,
  output logic                  current_valid_o,
  output logic                  ok_o,
  output logic [2:0]            pid_state_o,
  output logic [5:0]            pid_parent_o,
  output logic [5:0]            allocated_pid_o
);
  import pps_pkg::*;

  localparam int unsigned NSLOTS = (MAX_PROCS < 64) ? MAX_PROCS : 64;
  localparam int unsigned IW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int unsigned CW     = IW + 1;
  localparam int unsigned PB     = PRIORITY_BITS;

  // One memory word per entry: state, priority, parent, child bitmap.
  typedef struct packed {
    logic [2:0]        st;
    logic [PB-1:0]     prio;
    logic [PidW-1:0]   par;
    logic [NSLOTS-1:0] kids;
  } entry_t;

  // One-hot sequencer. Each read step issues an address; the next step sees the data.
  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_RD1   = 14'b00000000000100, // read the target (pid or current)
    S_EX1   = 14'b00000000001000, // act on target, read parent if needed
    S_EX2   = 14'b00000000010000, // read parent for exit
    S_RSCAN = 14'b00000000100000, // reap search over children
    S_RDONE = 14'b00000001000000,
    S_LNK1  = 14'b00000010000000, // read parent for link
    S_LNK2  = 14'b00000100000000,
    S_SCAN  = 14'b00001000000000, // best-entry search
    S_SCAND = 14'b00010000000000,
    S_UPD   = 14'b00100000000000, // rewrite ready entries
    S_RES   = 14'b01000000000000, // read pid for result
    S_OUT   = 14'b10000000000000
  } fsm_e;

  fsm_e                 state_q, state_d;
  entry_t               mem [NSLOTS];
  entry_t               rdata_q;
  logic                 we;
  logic [IW-1:0]        waddr, raddr;
  entry_t               wdata;
  logic                 re;

  logic [NSLOTS-1:0]    ready_q, ready_d, wpar_q, wpar_d;
  logic [PidW-1:0]      run_q, run_d, cnt_q, cnt_d;
  logic [CW-1:0]        idx_q, idx_d, last_q, last_d;
  logic                 found_q, found_d;
  logic [PB-1:0]        bp_q, bp_d;
  logic [IW-1:0]        best_q, best_d;
  logic                 ok_q, ok_d;
  logic [3:0]           fn_q, fn_d;
  logic [PidW-1:0]      pid_q, pid_d, ppid_q, ppid_d;
  logic [PB-1:0]        prio_q, prio_d;
  logic [IW-1:0]        tgt_q, tgt_d;
  logic [NSLOTS-1:0]    kids_q, kids_d;
  logic                 done_q, done_d;
  logic [2:0]           ost_q, ost_d;
  logic [PidW-1:0]      opar_q, opar_d;

  logic pid_ok, par_ok;
  assign pid_ok = {2'b0, pid_q} < 8'(NSLOTS);
  assign par_ok = {2'b0, ppid_q} < 8'(NSLOTS);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    wpar_d  = wpar_q;
    run_d   = run_q;
    cnt_d   = cfg_we_i ? cfg_wdata_i : cnt_q;
    idx_d   = idx_q;
    last_d  = last_q;
    found_d = found_q;
    bp_d    = bp_q;
    best_d  = best_q;
    ok_d    = ok_q;
    fn_d    = fn_q;
    pid_d   = pid_q;
    ppid_d  = ppid_q;
    prio_d  = prio_q;
    tgt_d   = tgt_q;
    kids_d  = kids_q;
    done_d  = 1'b0;
    ost_d   = ost_q;
    opar_d  = opar_q;
    we      = 1'b0;
    waddr   = tgt_q;
    wdata   = rdata_q;
    re      = 1'b0;
    raddr   = tgt_q;

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = idx_q[IW-1:0];
        wdata = '0;
        idx_d = idx_q + 1'b1;
        if (idx_q == CW'(NSLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          fn_d   = func_i;
          pid_d  = pid_i;
          ppid_d = parent_pid_i;
          prio_d = PB'(priority_req_i);
          ok_d   = 1'b1;
          if (func_i == FN_EXIT || func_i == FN_WAIT || func_i == FN_BLOCK) begin
            tgt_d = run_q[IW-1:0];
          end else begin
            tgt_d = pid_i[IW-1:0];
          end
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        re      = 1'b1;
        state_d = S_EX1;
        unique case (fn_q)
          FN_EXIT, FN_BLOCK: begin
            if (ready_q == '0) state_d = S_SCAN;
          end
          FN_WAIT: begin
            ok_d = 1'b0;
            if (ready_q == '0) state_d = S_SCAN;
          end
          FN_ADD, FN_TERM: begin
            if (!pid_ok) state_d = S_SCAN;
          end
          FN_UNBLOCK: begin
            if (!pid_ok || pid_q <= 6'd1) state_d = S_SCAN;
          end
          FN_LINK: begin
            if (!pid_ok || !par_ok) state_d = S_SCAN;
          end
          FN_ALLOC: begin
            if (cnt_q >= PidMax) ok_d = 1'b0;
            else cnt_d = cnt_q + 1'b1;
            state_d = S_SCAN;
          end
          default: state_d = S_SCAN;
        endcase
        idx_d   = '0;
        found_d = 1'b0;
      end
      S_EX1: begin
        state_d = S_SCAN;
        we      = 1'b1;
        waddr   = tgt_q;
        wdata   = rdata_q;
        unique case (fn_q)
          FN_ADD: begin
            wdata.prio = prio_q;
            wdata.par  = '0;
            wdata.kids = '0;
            ready_d[tgt_q] = 1'b1;
          end
          FN_EXIT: begin
            wdata.st = ST_TERMINATED;
            ready_d[tgt_q] = 1'b0;
            if ({2'b0, rdata_q.par} < 8'(NSLOTS) && wpar_q[rdata_q.par[IW-1:0]]) begin
              ppid_d  = rdata_q.par;
              state_d = S_EX2;
            end
          end
          FN_WAIT: begin
            we = 1'b0;
            if (rdata_q.kids != '0) begin
              kids_d  = rdata_q.kids;
              state_d = S_RSCAN;
            end
          end
          FN_BLOCK: begin
            wdata.st = ST_WAITING;
            ready_d[tgt_q] = 1'b0;
          end
          FN_UNBLOCK: begin
            wdata.st = ST_READY;
            ready_d[tgt_q] = 1'b1;
          end
          FN_TERM: begin
            wdata.st = ST_TERMINATED;
            ready_d[tgt_q] = 1'b0;
          end
          FN_LINK: begin
            wdata.par  = ppid_q;
            wdata.kids = '0;
            state_d    = S_LNK1;
          end
          default: we = 1'b0;
        endcase
      end
      S_EX2: begin
        // issue parent read; data arrives next cycle in S_LNK2 style handling
        re    = 1'b1;
        raddr = ppid_q[IW-1:0];
        state_d = S_LNK2;
      end
      S_LNK1: begin
        re    = 1'b1;
        raddr = ppid_q[IW-1:0];
        state_d = S_LNK2;
      end
      S_LNK2: begin
        we    = 1'b1;
        waddr = ppid_q[IW-1:0];
        wdata = rdata_q;
        if (fn_q == FN_LINK) begin
          // A process linked to itself ends with an empty child bitmap.
          if (ppid_q != pid_q) begin
            wdata.kids[pid_q[IW-1:0]] = 1'b1;
          end
        end else begin
          wdata.kids[tgt_q] = 1'b0;
          ready_d[ppid_q[IW-1:0]] = 1'b1;
          wpar_d[ppid_q[IW-1:0]]  = 1'b0;
        end
        state_d = S_SCAN;
      end
      S_RSCAN: begin
        // issue reads of all entries in index order; check each child's data in the step after its read
        if (idx_q != '0 && found_q == 1'b0 && kids_q[last_q[IW-1:0]] &&
            rdata_q.st == ST_TERMINATED) begin
          found_d = 1'b1;
          best_d  = last_q[IW-1:0];
        end
        if (idx_q == CW'(NSLOTS) || found_d) begin
          state_d = S_RDONE;
        end else begin
          re    = 1'b1;
          raddr = idx_q[IW-1:0];
          last_d = idx_q;
          idx_d  = idx_q + 1'b1;
        end
      end
      S_RDONE: begin
        we    = 1'b1;
        waddr = tgt_q;
        wdata = rdata_q;
        // rdata_q no longer holds the current entry, so nothing is written here
        re    = 1'b0;
        if (found_q) begin
          state_d = S_LNK1;
          fn_d    = FN_LINK;
          we      = 1'b0;
        end else begin
          we = 1'b0;
          state_d = S_LNK1;
          fn_d    = FN_BLOCK;
        end
        // both paths re-read the current entry through the link states below
        ppid_d  = PidW'(tgt_q);
        idx_d   = '0;
      end
      S_SCAN: begin
        if (idx_q != '0 && ready_q[last_q[IW-1:0]] &&
            (!found_q || rdata_q.prio > bp_q)) begin
          found_d = 1'b1;
          bp_d    = rdata_q.prio;
          best_d  = last_q[IW-1:0];
        end
        if (idx_q == CW'(NSLOTS)) begin
          state_d = S_SCAND;
        end else begin
          re     = 1'b1;
          raddr  = idx_q[IW-1:0];
          last_d = idx_q;
          idx_d  = idx_q + 1'b1;
        end
      end
      S_SCAND: begin
        if (found_q) run_d = PidW'(best_q);
        idx_d   = '0;
        state_d = found_q ? S_UPD : S_RES;
      end
      S_UPD: begin
        if (idx_q != '0 && ready_q[last_q[IW-1:0]]) begin
          we    = 1'b1;
          waddr = last_q[IW-1:0];
          wdata = rdata_q;
          wdata.st = (last_q[IW-1:0] == best_q) ? ST_RUNNING : ST_READY;
        end
        if (idx_q == CW'(NSLOTS)) begin
          state_d = S_RES;
        end else begin
          re     = 1'b1;
          raddr  = idx_q[IW-1:0];
          last_d = idx_q;
          idx_d  = idx_q + 1'b1;
        end
      end
      S_RES: begin
        re      = 1'b1;
        raddr   = pid_q[IW-1:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        ost_d   = pid_ok ? rdata_q.st : 3'd0;
        opar_d  = pid_ok ? rdata_q.par : '0;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // The wait-for-child tail is handled by the link states with special codes.
    if (state_q == S_LNK2 && fn_q == FN_BLOCK) begin
      we    = 1'b1;
      waddr = ppid_q[IW-1:0];
      wdata = rdata_q;
      wdata.st = ST_WAITING;
      wdata.kids = rdata_q.kids;
      ready_d = ready_q;
      ready_d[ppid_q[IW-1:0]] = 1'b0;
      wpar_d  = wpar_q;
      wpar_d[ppid_q[IW-1:0]] = 1'b1;
      ok_d    = 1'b1;
      idx_d   = '0;
      found_d = 1'b0;
    end
    if (state_q == S_LNK2 && fn_q == FN_LINK && found_q && tgt_q == ppid_q[IW-1:0] &&
        best_q != tgt_q) begin
      // reap: clear the terminated child in the current entry
      wdata = rdata_q;
      wdata.kids[best_q] = 1'b0;
    end
    if (state_q == S_LNK2) begin
      idx_d   = '0;
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ready_q <= '0;
      wpar_q  <= '0;
      run_q   <= '0;
      cnt_q   <= 6'd1;
      idx_q   <= '0;
      last_q  <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
      fn_q    <= '0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      wpar_q  <= wpar_d;
      run_q   <= run_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      found_q <= found_d;
      done_q  <= done_d;
      fn_q    <= fn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q   <= bp_d;
    best_q <= best_d;
    ok_q   <= ok_d;
    pid_q  <= pid_d;
    ppid_q <= ppid_d;
    prio_q <= prio_d;
    tgt_q  <= tgt_d;
    kids_q <= kids_d;
    ost_q  <= ost_d;
    opar_q <= opar_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign current_pid_o   = run_q;
  assign current_valid_o = (ready_q != '0);
  assign ok_o            = ok_q;
  assign pid_state_o     = ost_q;
  assign pid_parent_o    = opar_q;
  assign allocated_pid_o = cnt_q;

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state not one-hot");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("result shown while busy");
  a_run_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (ready_q != '0) |-> ready_q[run_q[IW-1:0]])
    else $error("running entry not ready");
`endif

endmodule

// ===== tb/priority_process_scheduler_core_test.sv =====
`timescale 1ns / 1ps
module priority_process_scheduler_core_test;
  import pps_pkg::*;

  // Codes 9 to 15 are not assigned and behave as a plain read.
  localparam logic [3:0] FnReservedTop = 4'd15;
  localparam int unsigned NumSlots = 64;
  localparam int unsigned RandomPerPhase = 226;

  // One result as the block presents it on its result ports.
  typedef struct packed {
    logic [5:0] cur_pid;
    logic       cur_valid;
    logic       ok;
    logic [2:0] state;
    logic [5:0] parent;
    logic [5:0] counter;
  } sched_result_t;

  // One row of the directed table: the command fields and, where it is plain
  // to see, the result typed in by hand.
  typedef struct packed {
    logic [3:0]    func;
    logic [5:0]    pid;
    logic [7:0]    prio;
    logic [5:0]    par;
    bit            typed;
    sched_result_t res;
  } cmd_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic [3:0] func_i;
  logic [5:0] pid_i;
  logic [7:0] priority_req_i;
  logic [5:0] parent_pid_i;
  logic       cfg_we_i;
  logic [5:0] cfg_wdata_i;
  logic       done_o;
  logic [5:0] current_pid_o;
  logic       current_valid_o;
  logic       ok_o;
  logic [2:0] pid_state_o;
  logic [5:0] pid_parent_o;
  logic [5:0] allocated_pid_o;

  priority_process_scheduler_core #(
    .MAX_PROCS    (64),
    .PRIORITY_BITS(8)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .func_i,
    .pid_i,
    .priority_req_i,
    .parent_pid_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .done_o,
    .current_pid_o,
    .current_valid_o,
    .ok_o,
    .pid_state_o,
    .pid_parent_o,
    .allocated_pid_o
  );

  // Our own copy of the process table, kept in step with every accepted item.
  pstate_e     tbl_state [NumSlots];
  logic [7:0]  tbl_prio  [NumSlots];
  logic [5:0]  tbl_parent[NumSlots];
  logic [63:0] tbl_children[NumSlots];
  logic [63:0] ready_set;
  logic [63:0] waiting_parents;
  logic [5:0]  running;
  logic [5:0]  pid_count;

  sched_result_t pending_results[$];
  int unsigned   failures;
  int unsigned   items_sent;
  int unsigned   results_seen;
  int unsigned   settings_used;
  int unsigned   burst_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Generous ceiling for all items plus gaps.
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  // Reset values of the table; the counter comes from the register.
  task automatic clear_table(input logic [5:0] start_value);
    for (int i = 0; i < NumSlots; i++) begin
      tbl_state[i]    = ST_NEW;
      tbl_prio[i]     = '0;
      tbl_parent[i]   = '0;
      tbl_children[i] = '0;
    end
    ready_set       = '0;
    waiting_parents = '0;
    running         = '0;
    pid_count       = start_value;
  endtask

  // Pick the highest-priority ready entry, lowest PID on a tie, and mark it
  // running while every other ready entry goes back to ready.
  function automatic void pick_running();
    bit         found;
    logic [5:0] best;
    logic [7:0] best_prio;
    found     = 1'b0;
    best      = '0;
    best_prio = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (ready_set[i] && (!found || tbl_prio[i] > best_prio)) begin
        found     = 1'b1;
        best      = 6'(i);
        best_prio = tbl_prio[i];
      end
    end
    if (found) begin
      running = best;
      for (int i = 0; i < NumSlots; i++) begin
        if (ready_set[i]) tbl_state[i] = (i == best) ? ST_RUNNING : ST_READY;
      end
    end
  endfunction

  // Apply one command to the table and return the result it should give.
  function automatic sched_result_t schedule_step(input logic [3:0] func, input logic [5:0] pid,
                                                  input logic [7:0] prio, input logic [5:0] par);
    sched_result_t res;
    bit            had_ready;
    bit            reaped;
    logic [5:0]    cur;
    logic [5:0]    up;
    had_ready = (ready_set != '0);
    cur       = running;
    res.ok    = 1'b1;
    case (func)
      FN_ADD: begin
        tbl_prio[pid]     = prio;
        tbl_parent[pid]   = '0;
        tbl_children[pid] = '0;
        ready_set[pid]    = 1'b1;
      end
      FN_EXIT: begin
        if (had_ready) begin
          up             = tbl_parent[cur];
          tbl_state[cur] = ST_TERMINATED;
          ready_set[cur] = 1'b0;
          // A parent sleeping on its children is woken by this exit.
          if (waiting_parents[up]) begin
            ready_set[up]         = 1'b1;
            tbl_children[up][cur] = 1'b0;
            waiting_parents[up]   = 1'b0;
          end
        end
      end
      FN_WAIT: begin
        res.ok = 1'b0;
        if (had_ready && tbl_children[cur] != '0) begin
          reaped = 1'b0;
          for (int i = 0; i < NumSlots; i++) begin
            if (!reaped && tbl_children[cur][i] && tbl_state[i] == ST_TERMINATED) begin
              tbl_children[cur][i] = 1'b0;
              reaped = 1'b1;
            end
          end
          if (!reaped) begin
            tbl_state[cur]       = ST_WAITING;
            waiting_parents[cur] = 1'b1;
            ready_set[cur]       = 1'b0;
            res.ok               = 1'b1;
          end
        end
      end
      FN_BLOCK: begin
        if (had_ready) begin
          tbl_state[cur] = ST_WAITING;
          ready_set[cur] = 1'b0;
        end
      end
      FN_UNBLOCK: begin
        if (pid > 6'd1) begin
          tbl_state[pid] = ST_READY;
          ready_set[pid] = 1'b1;
        end
      end
      FN_TERM: begin
        ready_set[pid] = 1'b0;
        tbl_state[pid] = ST_TERMINATED;
      end
      FN_LINK: begin
        tbl_children[par][pid] = 1'b1;
        tbl_parent[pid]        = par;
        tbl_children[pid]      = '0;
      end
      FN_ALLOC: begin
        if (pid_count >= PidMax) res.ok = 1'b0;
        else pid_count = pid_count + 6'd1;
      end
      default: begin
      end
    endcase
    pick_running();
    res.cur_pid   = running;
    res.cur_valid = (ready_set != '0);
    res.state     = tbl_state[pid];
    res.parent    = tbl_parent[pid];
    res.counter   = pid_count;
    return res;
  endfunction

  // Every result strobe is matched against the oldest outstanding expectation.
  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result arrived with nothing outstanding");
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (current_pid_o !== want.cur_pid) begin
          $error("current_pid: expected %0d, actual %0d", want.cur_pid, current_pid_o);
          failures++;
        end
        if (current_valid_o !== want.cur_valid) begin
          $error("current_valid: expected %0d, actual %0d", want.cur_valid, current_valid_o);
          failures++;
        end
        if (ok_o !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, ok_o);
          failures++;
        end
        if (pid_state_o !== want.state) begin
          $error("pid_state: expected %0d, actual %0d", want.state, pid_state_o);
          failures++;
        end
        if (pid_parent_o !== want.parent) begin
          $error("pid_parent: expected %0d, actual %0d", want.parent, pid_parent_o);
          failures++;
        end
        if (allocated_pid_o !== want.counter) begin
          $error("allocated_pid: expected %0d, actual %0d", want.counter, allocated_pid_o);
          failures++;
        end
      end
    end
  end

  // Present one item and hold it until the block takes it. The sender runs in
  // bursts: within a burst items follow back to back, between bursts start
  // drops for a random number of cycles.
  task automatic send_item(input cmd_row_t row);
    sched_result_t predicted;
    int unsigned   gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    func_i         <= row.func;
    pid_i          <= row.pid;
    priority_req_i <= row.prio;
    parent_pid_i   <= row.par;
    do @(posedge clk_i); while (busy_o);
    predicted = schedule_step(row.func, row.pid, row.prio, row.par);
    pending_results = {pending_results, (row.typed ? row.res : predicted)};
    items_sent++;
  endtask

  // The register is only touched once the block has drained and gone quiet.
  task automatic load_counter(input logic [5:0] value);
    start_i <= 1'b0;
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    pid_count = value;
    settings_used++;
  endtask

  // Random commands mostly aim at a handful of PIDs so that parents, children,
  // exits and waits run into each other; some use the whole PID range.
  function automatic cmd_row_t random_cmd();
    cmd_row_t    row;
    int unsigned pick;
    bit          wide;
    row       = '0;
    wide      = ($urandom_range(0, 4) == 0);
    row.pid   = wide ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 9));
    row.par   = wide ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 9));
    row.prio  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 3));
    pick      = $urandom_range(0, 99);
    if (pick < 22) row.func = FN_ADD;
    else if (pick < 32) row.func = FN_EXIT;
    else if (pick < 44) row.func = FN_WAIT;
    else if (pick < 50) row.func = FN_BLOCK;
    else if (pick < 60) row.func = FN_UNBLOCK;
    else if (pick < 67) row.func = FN_TERM;
    else if (pick < 82) row.func = FN_LINK;
    else if (pick < 88) row.func = FN_ALLOC;
    else if (pick < 95) row.func = FN_READ;
    else row.func = 4'($urandom_range(9, 15));
    return row;
  endfunction

  initial begin
    cmd_row_t    directed[22];
    logic [5:0]  phase_start[5];
    int unsigned wait_cycles;

    // Hand-typed rows assume the counter has been loaded with 62.
    directed = '{
      '{FN_READ,    6'd0,  8'd0,   6'd0, 1'b1, '{6'd0, 1'b0, 1'b1, ST_NEW,     6'd0, 6'd62}},
      '{FN_ALLOC,   6'd0,  8'd0,   6'd0, 1'b1, '{6'd0, 1'b0, 1'b1, ST_NEW,     6'd0, 6'd63}},
      '{FN_ALLOC,   6'd0,  8'd0,   6'd0, 1'b1, '{6'd0, 1'b0, 1'b0, ST_NEW,     6'd0, 6'd63}},
      '{FN_EXIT,    6'd0,  8'd0,   6'd0, 1'b1, '{6'd0, 1'b0, 1'b1, ST_NEW,     6'd0, 6'd63}},
      '{FN_WAIT,    6'd0,  8'd0,   6'd0, 1'b1, '{6'd0, 1'b0, 1'b0, ST_NEW,     6'd0, 6'd63}},
      '{FN_BLOCK,   6'd0,  8'd0,   6'd0, 1'b1, '{6'd0, 1'b0, 1'b1, ST_NEW,     6'd0, 6'd63}},
      '{FN_ADD,     6'd5,  8'd255, 6'd0, 1'b1, '{6'd5, 1'b1, 1'b1, ST_RUNNING, 6'd0, 6'd63}},
      '{FN_ADD,     6'd63, 8'd255, 6'd0, 1'b0, '0},
      '{FN_ADD,     6'd0,  8'd0,   6'd0, 1'b0, '0},
      '{FN_ADD,     6'd10, 8'd200, 6'd0, 1'b0, '0},
      '{FN_LINK,    6'd10, 8'd0,   6'd5, 1'b0, '0},
      '{FN_LINK,    6'd20, 8'd0,   6'd5, 1'b0, '0},
      '{FN_WAIT,    6'd5,  8'd0,   6'd0, 1'b0, '0},
      '{FN_EXIT,    6'd63, 8'd0,   6'd0, 1'b0, '0},
      '{FN_TERM,    6'd10, 8'd0,   6'd0, 1'b0, '0},
      '{FN_UNBLOCK, 6'd0,  8'd0,   6'd0, 1'b0, '0},
      '{FN_UNBLOCK, 6'd1,  8'd0,   6'd0, 1'b0, '0},
      '{FN_UNBLOCK, 6'd5,  8'd0,   6'd0, 1'b0, '0},
      '{FN_LINK,    6'd7,  8'd0,   6'd7, 1'b0, '0},
      '{FN_ADD,     6'd9,  8'd0,   6'd0, 1'b0, '0},
      '{FN_ADD,     6'd9,  8'd128, 6'd0, 1'b0, '0},
      '{FnReservedTop, 6'd9, 8'd0, 6'd0, 1'b0, '0}
    };
    phase_start = '{6'd0, 6'd63, 6'd1, 6'd61, 6'($urandom_range(0, 63))};

    failures      = 0;
    items_sent    = 0;
    results_seen  = 0;
    settings_used = 0;
    burst_left    = 0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    func_i         = FN_READ;
    pid_i          = '0;
    priority_req_i = '0;
    parent_pid_i   = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    clear_table(6'd1);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_counter(6'd62);
    foreach (directed[i]) send_item(directed[i]);

    // Each phase runs with a different counter start; the table carries over.
    foreach (phase_start[p]) begin
      load_counter(phase_start[p]);
      for (int n = 0; n < RandomPerPhase; n++) send_item(random_cmd());
    end
    start_i <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (200) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      failures++;
    end

    $display("Ran %0d commands under %0d counter start values; %0d results compared.",
             items_sent, settings_used, results_seen);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
